// ----- rtl/tlm_pkg.sv -----
// ----------------------------------------------------------------------------
// tlm_pkg: shared types and constants for the thruster lag model
// Fixed-point constants, register indexes, configuration bundle and the
// command word from the controller to the datapath.
// ----------------------------------------------------------------------------
package tlm_pkg;

    // Fraction bits of the Q formats on the ports
    localparam int FRAC_BITS = 16;

    // Value 1.0 in Q1.16 (throttle and lag coefficients)
    localparam logic [16:0] ONE_FX = 17'(1 << FRAC_BITS);

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SCALED_FULL_THRUST = 3'd0,
        REG_RISE_COEFF         = 3'd1,
        REG_FALL_COEFF         = 3'd2,
        REG_MIN_THRUST         = 3'd3,
        REG_DIR_X              = 3'd4,
        REG_DIR_Y              = 3'd5,
        REG_DIR_Z              = 3'd6,
        REG_FLOW_PER_NEWTON    = 3'd7
    } tlm_reg_t;

    // Reset value of the z direction: straight along the axis
    localparam logic signed [17:0] DIR_Z_RESET = 18'sd65536;

    // Configuration register bundle
    typedef struct packed {
        logic [31:0]        scaled_full_thrust;
        logic [16:0]        rise_coeff;
        logic [16:0]        fall_coeff;
        logic [31:0]        min_thrust;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic signed [17:0] dir_z;
        logic [31:0]        flow_per_newton;
    } tlm_cfg_t;

    // Operand selection of the shared multiplier
    typedef enum logic [2:0] {
        MUL_TGT,
        MUL_LAG,
        MUL_NOISE,
        MUL_FLOW,
        MUL_FX,
        MUL_FY,
        MUL_FZ
    } tlm_mul_t;

    // Write-back of the previous product
    typedef enum logic [2:0] {
        WB_NONE,
        WB_TGT,
        WB_LAG,
        WB_MIN,
        WB_NOISE,
        WB_FLOW,
        WB_FX,
        WB_FY
    } tlm_wb_t;

    // Controller to datapath command word
    typedef struct packed {
        logic     capture;
        logic     mul_en;
        tlm_mul_t mul_sel;
        tlm_wb_t  wb_sel;
        logic     load_out;
        logic     load_hold;
    } tlm_cmd_t;

endpackage

// ----- rtl/tlm_if.sv -----
// ----------------------------------------------------------------------------
// tlm_if: channel interfaces of the thruster lag model
// Input word, result word and configuration write channels, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface tlm_item_if;
    logic               valid;
    logic               ready;
    logic [16:0]        throttle_cmd;
    logic               force_off;
    logic               force_on;
    logic signed [18:0] noise_term;
    logic               hold;

    modport source (output valid, throttle_cmd, force_off, force_on, noise_term, hold,
                    input ready);
    modport sink   (input valid, throttle_cmd, force_off, force_on, noise_term, hold,
                    output ready);
endinterface

interface tlm_result_if;
    logic               valid;
    logic               ready;
    logic [31:0]        delivered_thrust;
    logic signed [32:0] force_x;
    logic signed [32:0] force_y;
    logic signed [32:0] force_z;
    logic [47:0]        mass_flow;
    logic [16:0]        applied_throttle;

    modport source (output valid, delivered_thrust, force_x, force_y, force_z,
                    mass_flow, applied_throttle, input ready);
    modport sink   (input valid, delivered_thrust, force_x, force_y, force_z,
                    mass_flow, applied_throttle, output ready);
endinterface

interface tlm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/tlm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tlm_cfg_regs: configuration register file
// Takes one register write per accepted word and presents all registers
// as one bundle.
// ----------------------------------------------------------------------------
module tlm_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [2:0]        wr_index,
    input  logic [31:0]       wr_data,
    output tlm_pkg::tlm_cfg_t regs
);

    tlm_pkg::tlm_cfg_t regs_reg;

    // Always ready for a write
    assign wr_ready = 1'b1;
    assign regs     = regs_reg;

    // Update the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg                    <= '0;
            regs_reg.dir_z              <= tlm_pkg::DIR_Z_RESET;
        end
        else if (wr_valid)
        begin
            case (tlm_pkg::tlm_reg_t'(wr_index))
                tlm_pkg::REG_SCALED_FULL_THRUST: regs_reg.scaled_full_thrust <= wr_data;
                tlm_pkg::REG_RISE_COEFF:         regs_reg.rise_coeff <= wr_data[16:0];
                tlm_pkg::REG_FALL_COEFF:         regs_reg.fall_coeff <= wr_data[16:0];
                tlm_pkg::REG_MIN_THRUST:         regs_reg.min_thrust <= wr_data;
                tlm_pkg::REG_DIR_X:              regs_reg.dir_x <= $signed(wr_data[17:0]);
                tlm_pkg::REG_DIR_Y:              regs_reg.dir_y <= $signed(wr_data[17:0]);
                tlm_pkg::REG_DIR_Z:              regs_reg.dir_z <= $signed(wr_data[17:0]);
                tlm_pkg::REG_FLOW_PER_NEWTON:    regs_reg.flow_per_newton <= wr_data;
                default:                         regs_reg <= regs_reg;
            endcase
        end
    end

endmodule

// ----- rtl/tlm_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlm_ctrl: step sequencer of the thruster lag model
// Walks one input word through the multiply and write-back steps of the
// shared multiplier and owns the handshake of both data channels.
// ----------------------------------------------------------------------------
module tlm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_hold,
    output logic              item_ready,
    output logic              result_valid,
    input  logic              result_ready,
    output tlm_pkg::tlm_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TGT_MUL,
        S_TGT_WB,
        S_LAG_MUL,
        S_LAG_WB,
        S_MIN,
        S_NOISE_MUL,
        S_NOISE_WB,
        S_FLOW_MUL,
        S_FX_MUL,
        S_FY_MUL,
        S_FZ_MUL,
        S_DONE,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   slot_free;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign slot_free    = !result_valid_reg || result_ready;

    // Decode the step into a datapath command and pick the next step
    always_comb
    begin
        cmd               = '0;
        cmd.mul_sel       = tlm_pkg::MUL_TGT;
        cmd.wb_sel        = tlm_pkg::WB_NONE;
        state_next        = state_reg;
        result_valid_next = result_ready ? 1'b0 : result_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = item_hold ? S_HOLD : S_TGT_MUL;
                end
            end
            S_TGT_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tlm_pkg::MUL_TGT;
                state_next  = S_TGT_WB;
            end
            S_TGT_WB:
            begin
                cmd.wb_sel = tlm_pkg::WB_TGT;
                state_next = S_LAG_MUL;
            end
            S_LAG_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tlm_pkg::MUL_LAG;
                state_next  = S_LAG_WB;
            end
            S_LAG_WB:
            begin
                cmd.wb_sel = tlm_pkg::WB_LAG;
                state_next = S_MIN;
            end
            S_MIN:
            begin
                cmd.wb_sel = tlm_pkg::WB_MIN;
                state_next = S_NOISE_MUL;
            end
            S_NOISE_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tlm_pkg::MUL_NOISE;
                state_next  = S_NOISE_WB;
            end
            S_NOISE_WB:
            begin
                cmd.wb_sel = tlm_pkg::WB_NOISE;
                state_next = S_FLOW_MUL;
            end
            S_FLOW_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tlm_pkg::MUL_FLOW;
                state_next  = S_FX_MUL;
            end
            S_FX_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tlm_pkg::MUL_FX;
                cmd.wb_sel  = tlm_pkg::WB_FLOW;
                state_next  = S_FY_MUL;
            end
            S_FY_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tlm_pkg::MUL_FY;
                cmd.wb_sel  = tlm_pkg::WB_FX;
                state_next  = S_FZ_MUL;
            end
            S_FZ_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tlm_pkg::MUL_FZ;
                cmd.wb_sel  = tlm_pkg::WB_FY;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // Wait until the output register is free, then load it
                if (slot_free)
                begin
                    cmd.load_out      = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.load_out      = 1'b1;
                    cmd.load_hold     = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

// ----- rtl/tlm_dpath.sv -----
// ----------------------------------------------------------------------------
// tlm_dpath: datapath of the thruster lag model
// One shared 32x32 multiplier with a product register, the working
// registers of one step, the chamber thrust state and the output register.
// ----------------------------------------------------------------------------
module tlm_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  tlm_pkg::tlm_cmd_t   cmd,
    input  tlm_pkg::tlm_cfg_t   cfg_regs,
    input  logic [16:0]         throttle_cmd,
    input  logic                force_off,
    input  logic                force_on,
    input  logic signed [18:0]  noise_term,
    output logic [31:0]         delivered_thrust,
    output logic signed [32:0]  force_x,
    output logic signed [32:0]  force_y,
    output logic signed [32:0]  force_z,
    output logic [47:0]         mass_flow,
    output logic [16:0]         applied_throttle
);

    localparam int F = tlm_pkg::FRAC_BITS;

    // Magnitude of a signed direction cosine
    function automatic logic [17:0] dir_mag(input logic signed [17:0] d);
        logic [17:0] m;
        m = d[17] ? 18'(-d) : 18'(d);
        return m;
    endfunction

    // Shift down a force product, saturate and apply the sign
    function automatic logic signed [32:0] force_sat(input logic [63:0] p,
                                                     input logic neg);
        logic [47:0] m;
        logic [32:0] ms;
        m = p[F +: 48];
        if (neg)
        begin
            ms = (m > 48'h1_0000_0000) ? 33'h1_0000_0000 : m[32:0];
            return $signed(33'(-ms));
        end
        ms = (m > 48'hFFFF_FFFF) ? 33'h0_FFFF_FFFF : {1'b0, m[31:0]};
        return $signed(ms);
    endfunction

    logic [16:0]        cmd_sat;
    logic signed [19:0] factor;
    logic [16:0]        coeff_raw;
    logic [16:0]        coeff;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [31:0]        shifted_sat;
    logic [31:0]        lag_prod;
    logic [31:0]        tgt_next;

    logic [63:0]        prod_reg;
    logic [16:0]        thr_reg;
    logic [16:0]        cmd_sat_reg;
    logic [18:0]        fac_mag_reg;
    logic               fac_pos_reg;
    logic [31:0]        target_reg;
    logic               rise_reg;
    logic [31:0]        diff_reg;
    logic [31:0]        chamber_reg;
    logic [31:0]        chamber_next;
    logic [31:0]        del_reg;
    logic [47:0]        flow_reg;
    logic signed [32:0] fx_reg;
    logic signed [32:0] fy_reg;

    logic [31:0]        out_del_reg;
    logic signed [32:0] out_fx_reg;
    logic signed [32:0] out_fy_reg;
    logic signed [32:0] out_fz_reg;
    logic [47:0]        out_flow_reg;
    logic [16:0]        out_thr_reg;

    // Resolve the input word: saturated command and noise factor
    assign cmd_sat = (throttle_cmd > tlm_pkg::ONE_FX) ? tlm_pkg::ONE_FX : throttle_cmd;
    assign factor  = $signed({3'b000, tlm_pkg::ONE_FX}) + 20'(noise_term);

    // Pick the lag coefficient by direction, saturated at one
    assign coeff_raw = rise_reg ? cfg_regs.rise_coeff : cfg_regs.fall_coeff;
    assign coeff     = (coeff_raw > tlm_pkg::ONE_FX) ? tlm_pkg::ONE_FX : coeff_raw;

    // Shift the product down to the Q16.16 result and saturate at 32 bits
    assign shifted_sat = (|prod_reg[63:F+32]) ? 32'hFFFF_FFFF : prod_reg[F +: 32];
    assign lag_prod    = prod_reg[F +: 32];
    assign tgt_next    = shifted_sat;

    // Select multiplier operands
    always_comb
    begin
        case (cmd.mul_sel)
            tlm_pkg::MUL_TGT:
            begin
                mul_a = cfg_regs.scaled_full_thrust;
                mul_b = 32'(thr_reg);
            end
            tlm_pkg::MUL_LAG:
            begin
                mul_a = diff_reg;
                mul_b = 32'(coeff);
            end
            tlm_pkg::MUL_NOISE:
            begin
                mul_a = del_reg;
                mul_b = 32'(fac_mag_reg);
            end
            tlm_pkg::MUL_FLOW:
            begin
                mul_a = del_reg;
                mul_b = cfg_regs.flow_per_newton;
            end
            tlm_pkg::MUL_FX:
            begin
                mul_a = del_reg;
                mul_b = 32'(dir_mag(cfg_regs.dir_x));
            end
            tlm_pkg::MUL_FY:
            begin
                mul_a = del_reg;
                mul_b = 32'(dir_mag(cfg_regs.dir_y));
            end
            tlm_pkg::MUL_FZ:
            begin
                mul_a = del_reg;
                mul_b = 32'(dir_mag(cfg_regs.dir_z));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Move the chamber thrust toward the target, truncating toward it
    assign chamber_next = rise_reg ? (target_reg - lag_prod) : (target_reg + lag_prod);

    // Chamber thrust state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chamber_reg <= '0;
        end
        else if (cmd.wb_sel == tlm_pkg::WB_LAG)
        begin
            chamber_reg <= chamber_next;
        end
    end

    // Capture input, multiply and write back working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            thr_reg     <= force_off ? 17'd0 : (force_on ? tlm_pkg::ONE_FX : cmd_sat);
            cmd_sat_reg <= cmd_sat;
            fac_mag_reg <= factor[18:0];
            fac_pos_reg <= !factor[19] && (factor != 20'sd0);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.wb_sel)
            tlm_pkg::WB_TGT:
            begin
                target_reg <= tgt_next;
                rise_reg   <= tgt_next > chamber_reg;
                diff_reg   <= (tgt_next > chamber_reg) ? (tgt_next - chamber_reg)
                                                       : (chamber_reg - tgt_next);
            end
            tlm_pkg::WB_MIN:
            begin
                // Drop thrust below the minimum impulse level
                del_reg <= ((cfg_regs.min_thrust != 32'd0) &&
                            (chamber_reg < cfg_regs.min_thrust)) ? 32'd0 : chamber_reg;
            end
            tlm_pkg::WB_NOISE:
            begin
                del_reg <= fac_pos_reg ? shifted_sat : 32'd0;
            end
            tlm_pkg::WB_FLOW:
            begin
                flow_reg <= prod_reg[F +: 48];
            end
            tlm_pkg::WB_FX:
            begin
                fx_reg <= force_sat(prod_reg, cfg_regs.dir_x[17]);
            end
            tlm_pkg::WB_FY:
            begin
                fy_reg <= force_sat(prod_reg, cfg_regs.dir_y[17]);
            end
            default:
            begin
                del_reg <= del_reg;
            end
        endcase
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (cmd.load_hold)
            begin
                out_del_reg  <= chamber_reg;
                out_fx_reg   <= '0;
                out_fy_reg   <= '0;
                out_fz_reg   <= '0;
                out_flow_reg <= '0;
                out_thr_reg  <= cmd_sat_reg;
            end
            else
            begin
                out_del_reg  <= del_reg;
                out_fx_reg   <= fx_reg;
                out_fy_reg   <= fy_reg;
                out_fz_reg   <= force_sat(prod_reg, cfg_regs.dir_z[17]);
                out_flow_reg <= flow_reg;
                out_thr_reg  <= thr_reg;
            end
        end
    end

    assign delivered_thrust = out_del_reg;
    assign force_x          = out_fx_reg;
    assign force_y          = out_fy_reg;
    assign force_z          = out_fz_reg;
    assign mass_flow        = out_flow_reg;
    assign applied_throttle = out_thr_reg;

endmodule

// ----- rtl/thruster_lag_model_step.sv -----
// ----------------------------------------------------------------------------
// thruster_lag_model_step: thruster thrust lag model, one tick per word
// Applies fault overrides, lags chamber thrust toward the target with
// separate rise and fall coefficients, applies the minimum impulse level and
// noise, and returns force along the configured direction and mass flow.
// ----------------------------------------------------------------------------
// A normal tick runs through eleven steps in which a single shared 32x32
// multiplier is used seven times: target, lag, noise, mass flow and the three
// force components. Each product is registered before its write-back. A final
// step loads the output register. A hold tick skips these steps and returns
// the current chamber thrust with zero force and mass flow. A new word is
// accepted in the cycle after the previous result is loaded into the output
// register. A result may wait in the output register while the next tick is
// computed. A tick that finishes while the output is still occupied waits for
// it to be taken. The configuration channel is always ready; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
module thruster_lag_model_step (
    input  logic         clk,
    input  logic         rst_n,
    tlm_item_if.sink     item,
    tlm_result_if.source result,
    tlm_cfg_if.sink      cfg
);

    tlm_pkg::tlm_cfg_t cfg_regs;
    tlm_pkg::tlm_cmd_t cmd;
    logic              item_ready;
    logic              result_valid;
    logic              cfg_ready;

    // Configuration registers
    tlm_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg_ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .regs     (cfg_regs)
    );

    // Step sequencer
    tlm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_hold    (item.hold),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    // Datapath
    tlm_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_regs         (cfg_regs),
        .throttle_cmd     (item.throttle_cmd),
        .force_off        (item.force_off),
        .force_on         (item.force_on),
        .noise_term       (item.noise_term),
        .delivered_thrust (result.delivered_thrust),
        .force_x          (result.force_x),
        .force_y          (result.force_y),
        .force_z          (result.force_z),
        .mass_flow        (result.mass_flow),
        .applied_throttle (result.applied_throttle)
    );

    assign item.ready   = item_ready;
    assign result.valid = result_valid;
    assign cfg.ready    = cfg_ready;

endmodule

// ----- tb/thruster_lag_model_step_test.sv -----
// ----------------------------------------------------------------------------
// thruster_lag_model_step_test: self-checking bench for the thruster lag model
// Drives tick words through a directed table and then random bursts under a
// series of register settings, predicts every unpinned result word from its own
// model of the lag, noise, force and mass flow math, and compares field by field.
// ----------------------------------------------------------------------------
module thruster_lag_model_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tlm_pkg::*;

    localparam int PHASES         = 10;
    localparam int TICKS_PER_PHASE = 160;
    localparam int LONG_HOLD_OFF  = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_LIMIT    = 40;
    localparam int PLAN_LEN       = 25;

    // One tick word as offered on the input channel
    typedef struct packed {
        logic [16:0]        throttle_cmd;
        logic               force_off;
        logic               force_on;
        logic signed [18:0] noise_term;
        logic               hold;
    } tick_t;

    // One result word
    typedef struct packed {
        logic [31:0] delivered;
        logic [32:0] force_x;
        logic [32:0] force_y;
        logic [32:0] force_z;
        logic [47:0] mass_flow;
        logic [16:0] throttle;
    } thrust_out_t;

    // Result typed into the table, used instead of the prediction when pinned
    typedef struct packed {
        bit          pinned;
        thrust_out_t answer;
    } answer_t;

    // Directed table row; forces x/y and mass flow are zero on pinned rows
    typedef struct packed {
        int                 cfg_sel;
        logic [16:0]        cmd;
        bit                 off;
        bit                 on;
        logic signed [18:0] noise;
        bit                 hold;
        bit                 pinned;
        logic [31:0]        del;
        logic [32:0]        fz;
        logic [16:0]        thr;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    tlm_item_if   item_ch ();
    tlm_result_if result_ch ();
    tlm_cfg_if    cfg_ch ();

    thruster_lag_model_step dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mirror of the block: register bank and chamber thrust
    tlm_cfg_t    cfg_mirror;
    logic [31:0] chamber;

    thrust_out_t due_outputs [$];
    answer_t     pinned_answers [$];
    int          mismatches    = 0;
    int          results_taken = 0;
    int          quiet_cycles  = 0;

    tlm_cfg_t    preset [1:3];

    // Directed table: reset settings, instant response, extremes, slow lag
    plan_row_t plan [PLAN_LEN] = '{
        '{-1, 17'd0,      1'b0, 1'b0, 19'sd0,       1'b0, 1'b1, 32'd0, 33'd0, 17'd0},
        '{-1, 17'd65536,  1'b0, 1'b0, 19'sd0,       1'b0, 1'b1, 32'd0, 33'd0, 17'd65536},
        '{-1, 17'd131071, 1'b0, 1'b0, 19'sd0,       1'b0, 1'b1, 32'd0, 33'd0, 17'd65536},
        '{-1, 17'd65537,  1'b1, 1'b1, 19'sd0,       1'b0, 1'b1, 32'd0, 33'd0, 17'd0},
        '{-1, 17'd0,      1'b0, 1'b1, 19'sd262143,  1'b0, 1'b1, 32'd0, 33'd0, 17'd65536},
        '{-1, 17'd131071, 1'b1, 1'b0, 19'sd0,       1'b1, 1'b1, 32'd0, 33'd0, 17'd65536},
        '{1,  17'd65536,  1'b0, 1'b0, 19'sd0,       1'b0, 1'b1,
          32'd6553600, 33'd6553600, 17'd65536},
        '{-1, 17'd65536,  1'b0, 1'b0, -19'sd65536,  1'b0, 1'b1, 32'd0, 33'd0, 17'd65536},
        '{-1, 17'd65536,  1'b0, 1'b0, 19'sd65536,   1'b0, 1'b1,
          32'd13107200, 33'd13107200, 17'd65536},
        '{-1, 17'd32768,  1'b0, 1'b0, 19'sd0,       1'b1, 1'b1, 32'd6553600, 33'd0, 17'd32768},
        '{-1, 17'd32768,  1'b0, 1'b0, 19'sd0,       1'b0, 1'b1,
          32'd3276800, 33'd3276800, 17'd32768},
        '{-1, 17'd65536,  1'b1, 1'b0, 19'sd0,       1'b0, 1'b1, 32'd0, 33'd0, 17'd0},
        '{-1, 17'd65536,  1'b0, 1'b0, -19'sd262144, 1'b0, 1'b1, 32'd0, 33'd0, 17'd65536},
        '{-1, 17'd65536,  1'b0, 1'b0, 19'sd131071,  1'b0, 1'b0, 32'd0, 33'd0, 17'd0},
        '{2,  17'd65536,  1'b0, 1'b0, 19'sd0,       1'b0, 1'b0, 32'd0, 33'd0, 17'd0},
        '{-1, 17'd65536,  1'b0, 1'b0, 19'sd262143,  1'b0, 1'b0, 32'd0, 33'd0, 17'd0},
        '{-1, 17'd32768,  1'b0, 1'b0, 19'sd0,       1'b0, 1'b0, 32'd0, 33'd0, 17'd0},
        '{-1, 17'd32768,  1'b0, 1'b0, -19'sd1,      1'b0, 1'b0, 32'd0, 33'd0, 17'd0},
        '{3,  17'd65536,  1'b0, 1'b0, 19'sd0,       1'b0, 1'b0, 32'd0, 33'd0, 17'd0},
        '{-1, 17'd65536,  1'b0, 1'b0, 19'sd0,       1'b0, 1'b0, 32'd0, 33'd0, 17'd0},
        '{-1, 17'd16384,  1'b0, 1'b0, 19'sd0,       1'b0, 1'b0, 32'd0, 33'd0, 17'd0},
        '{-1, 17'd16384,  1'b0, 1'b0, 19'sd0,       1'b0, 1'b0, 32'd0, 33'd0, 17'd0},
        '{-1, 17'd16384,  1'b0, 1'b0, 19'sd3000,    1'b0, 1'b0, 32'd0, 33'd0, 17'd0},
        '{-1, 17'd0,      1'b0, 1'b1, -19'sd3000,   1'b0, 1'b0, 32'd0, 33'd0, 17'd0},
        '{-1, 17'd1,      1'b0, 1'b0, 19'sd0,       1'b1, 1'b0, 32'd0, 33'd0, 17'd0}
    };

    // Force component: magnitude truncated toward zero, saturated to 33 bits
    function automatic logic [32:0] force_along(logic [63:0] thrust,
                                                logic signed [17:0] dir);
        logic signed [63:0] d;
        logic [63:0]        mag;
        logic [63:0]        p;
        d   = dir;
        mag = (d < 0) ? -d : d;
        p   = (thrust * mag) >> FRAC_BITS;
        if (d < 0)
        begin
            if (p > 64'h1_0000_0000)
                p = 64'h1_0000_0000;
            p = 64'd0 - p;
        end
        else if (p > 64'hFFFF_FFFF)
        begin
            p = 64'hFFFF_FFFF;
        end
        return p[32:0];
    endfunction

    // Advance the chamber thrust by one tick and return the result word
    function automatic thrust_out_t step_thruster(tick_t w);
        logic [63:0]        cmd;
        logic [63:0]        thr;
        logic [63:0]        target;
        logic [63:0]        coef;
        logic [63:0]        cur;
        logic [63:0]        del;
        logic [63:0]        flow;
        logic signed [63:0] factor;
        thrust_out_t        r;
        r   = '0;
        cmd = (w.throttle_cmd > ONE_FX) ? 64'(ONE_FX) : 64'(w.throttle_cmd);
        if (w.hold)
        begin
            r.delivered = chamber;
            r.throttle  = cmd[16:0];
            return r;
        end

        // Resolve faults, off wins over on
        thr = w.force_off ? 64'd0 : (w.force_on ? 64'(ONE_FX) : cmd);
        target = (thr * cfg_mirror.scaled_full_thrust) >> FRAC_BITS;
        if (target > 64'hFFFF_FFFF)
            target = 64'hFFFF_FFFF;

        // Lag toward the target, rounding toward the target
        if (target > chamber)
        begin
            coef = (cfg_mirror.rise_coeff > ONE_FX) ? 64'(ONE_FX) : 64'(cfg_mirror.rise_coeff);
            cur  = target - (((target - chamber) * coef) >> FRAC_BITS);
        end
        else
        begin
            coef = (cfg_mirror.fall_coeff > ONE_FX) ? 64'(ONE_FX) : 64'(cfg_mirror.fall_coeff);
            cur  = target + (((chamber - target) * coef) >> FRAC_BITS);
        end
        chamber = cur[31:0];

        // Drop thrust below the minimum impulse level
        del = chamber;
        if (cfg_mirror.min_thrust != 0 && del < cfg_mirror.min_thrust)
            del = 0;

        // Apply noise, clamping at zero and at full scale
        if (w.noise_term != 0 && del != 0)
        begin
            factor = w.noise_term;
            factor = factor + (64'sd1 << FRAC_BITS);
            if (factor <= 0)
                del = 0;
            else
            begin
                del = (del * factor) >> FRAC_BITS;
                if (del > 64'hFFFF_FFFF)
                    del = 64'hFFFF_FFFF;
            end
        end

        flow = 0;
        if (cfg_mirror.flow_per_newton != 0)
        begin
            flow = (del * cfg_mirror.flow_per_newton) >> FRAC_BITS;
            if (flow > 64'hFFFF_FFFF_FFFF)
                flow = 64'hFFFF_FFFF_FFFF;
        end

        r.delivered = del[31:0];
        r.force_x   = force_along(del, cfg_mirror.dir_x);
        r.force_y   = force_along(del, cfg_mirror.dir_y);
        r.force_z   = force_along(del, cfg_mirror.dir_z);
        r.mass_flow = flow[47:0];
        r.throttle  = thr[16:0];
        return r;
    endfunction

    function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: %s expected %h got %h", $time, what, want, got);
        end
    endfunction

    // Monitor: sample all three channels between edges, where everything is settled
    thrust_out_t observed;
    thrust_out_t predicted;
    tick_t       taken;
    answer_t     known;
    logic        moved;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;

            // Mirror register writes
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                moved = 1'b1;
                case (tlm_reg_t'(cfg_ch.index))
                    REG_SCALED_FULL_THRUST: cfg_mirror.scaled_full_thrust = cfg_ch.data;
                    REG_RISE_COEFF:         cfg_mirror.rise_coeff = cfg_ch.data[16:0];
                    REG_FALL_COEFF:         cfg_mirror.fall_coeff = cfg_ch.data[16:0];
                    REG_MIN_THRUST:         cfg_mirror.min_thrust = cfg_ch.data;
                    REG_DIR_X:              cfg_mirror.dir_x = cfg_ch.data[17:0];
                    REG_DIR_Y:              cfg_mirror.dir_y = cfg_ch.data[17:0];
                    REG_DIR_Z:              cfg_mirror.dir_z = cfg_ch.data[17:0];
                    REG_FLOW_PER_NEWTON:    cfg_mirror.flow_per_newton = cfg_ch.data;
                    default: ;
                endcase
            end

            // Check a result word against the oldest expectation
            if (result_ch.valid && result_ch.ready)
            begin
                moved = 1'b1;
                results_taken++;
                observed.delivered = result_ch.delivered_thrust;
                observed.force_x   = result_ch.force_x;
                observed.force_y   = result_ch.force_y;
                observed.force_z   = result_ch.force_z;
                observed.mass_flow = result_ch.mass_flow;
                observed.throttle  = result_ch.applied_throttle;
                if (due_outputs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT)
                        $display("%0t: result word with nothing expected, delivered %h",
                                 $time, observed.delivered);
                end
                else
                begin
                    predicted = due_outputs.pop_front();
                    compare_field("delivered_thrust", predicted.delivered, observed.delivered);
                    compare_field("force_x", predicted.force_x, observed.force_x);
                    compare_field("force_y", predicted.force_y, observed.force_y);
                    compare_field("force_z", predicted.force_z, observed.force_z);
                    compare_field("mass_flow", predicted.mass_flow, observed.mass_flow);
                    compare_field("applied_throttle", predicted.throttle, observed.throttle);
                end
            end

            // Predict each accepted tick word
            if (item_ch.valid && item_ch.ready)
            begin
                moved = 1'b1;
                taken.throttle_cmd = item_ch.throttle_cmd;
                taken.force_off    = item_ch.force_off;
                taken.force_on     = item_ch.force_on;
                taken.noise_term   = item_ch.noise_term;
                taken.hold         = item_ch.hold;
                predicted = step_thruster(taken);
                known = (pinned_answers.size() != 0) ? pinned_answers.pop_front() : '0;
                due_outputs.push_back(known.pinned ? known.answer : predicted);
            end

            // Watchdog on cycles with no word moving anywhere
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side: stall pattern picked at random from four modes, long hold-offs
    initial
    begin
        int cyc;
        int mode;
        int hold_at;
        result_ch.ready = 1'b0;
        cyc     = 0;
        mode    = 0;
        hold_at = 300;
        forever
        begin
            @(posedge clk);
            if (results_taken >= hold_at)
            begin
                hold_at += 500;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_OFF) @(posedge clk);
            end
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            cyc++;
            case (mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 1) == 0);
                2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= ((cyc % 8) < 3);
            endcase
        end
    end

    function automatic logic [16:0] pick_coeff();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(0, 131071));
            default: return 17'($urandom_range(30000, 65535));
        endcase
    endfunction

    function automatic logic signed [17:0] pick_dir();
        int v;
        if ($urandom_range(0, 3) == 0)
            v = $urandom_range(0, 262143) - 131072;
        else
            v = $urandom_range(0, 131072) - 65536;
        return v[17:0];
    endfunction

    function automatic tick_t pick_tick();
        tick_t t;
        int    n;
        case ($urandom_range(0, 7))
            0: t.throttle_cmd = 17'd0;
            1: t.throttle_cmd = ONE_FX;
            2: t.throttle_cmd = 17'($urandom_range(65537, 131071));
            default: t.throttle_cmd = 17'($urandom_range(0, 65536));
        endcase
        t.force_off = ($urandom_range(0, 9) == 0);
        t.force_on  = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 9))
            0, 1, 2: n = 0;
            8: n = $urandom_range(0, 524287) - 262144;
            9: n = ($urandom_range(0, 1) == 0) ? -262144 : 262143;
            default: n = $urandom_range(0, 8000) - 4000;
        endcase
        t.noise_term = n[18:0];
        t.hold = ($urandom_range(0, 9) == 0);
        return t;
    endfunction

    // Offer one tick word and return at the edge that takes it
    task automatic send_tick(tick_t w);
        item_ch.valid        <= 1'b1;
        item_ch.throttle_cmd <= w.throttle_cmd;
        item_ch.force_off    <= w.force_off;
        item_ch.force_on     <= w.force_on;
        item_ch.noise_term   <= w.noise_term;
        item_ch.hold         <= w.hold;
        do @(negedge clk); while (!item_ch.ready);
        @(posedge clk);
    endtask

    // Hold the input and wait until every result word has come back
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge clk);
    endtask

    // Write all eight registers back to back
    task automatic load_settings(tlm_cfg_t c);
        tlm_reg_t    idx;
        logic [31:0] d;
        idx = idx.first();
        repeat (8)
        begin
            case (idx)
                REG_SCALED_FULL_THRUST: d = c.scaled_full_thrust;
                REG_RISE_COEFF:         d = 32'(c.rise_coeff);
                REG_FALL_COEFF:         d = 32'(c.fall_coeff);
                REG_MIN_THRUST:         d = c.min_thrust;
                REG_DIR_X:              d = 32'(c.dir_x);
                REG_DIR_Y:              d = 32'(c.dir_y);
                REG_DIR_Z:              d = 32'(c.dir_z);
                default:                d = c.flow_per_newton;
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= d;
            do @(negedge clk); while (!cfg_ch.ready);
            @(posedge clk);
            idx = idx.next();
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        tlm_cfg_t  c;
        tick_t     t;
        answer_t   a;
        plan_row_t r;
        int        sent;
        int        burst;

        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.throttle_cmd = '0;
        item_ch.force_off    = 1'b0;
        item_ch.force_on     = 1'b0;
        item_ch.noise_term   = '0;
        item_ch.hold         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_SCALED_FULL_THRUST;
        cfg_ch.data          = '0;
        cfg_mirror           = '0;
        cfg_mirror.dir_z     = DIR_Z_RESET;
        chamber              = '0;

        // 100 N, instant response, straight along z
        preset[1] = '{32'd6553600, 17'd0, 17'd0, 32'd0, 18'sd0, 18'sd0, 18'sd65536, 32'd0};
        // Extremes: full scale, fall held, directions at the ends of the field
        preset[2] = '{32'hFFFF_FFFF, 17'd0, 17'h1FFFF, 32'd0, -18'sd131072, 18'sd131071,
                      -18'sd65536, 32'hFFFF_FFFF};
        // Slow rise, fast fall, 50 N minimum impulse level
        preset[3] = '{32'd6553600, 17'd49152, 17'd16384, 32'd3276800, 18'sd46341,
                      -18'sd46341, 18'sd0, 32'd1000000};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            r = plan[i];
            if (r.cfg_sel > 0)
            begin
                drain();
                load_settings(preset[r.cfg_sel]);
            end
            t = '{r.cmd, r.off, r.on, r.noise, r.hold};
            a = '0;
            a.pinned           = r.pinned;
            a.answer.delivered = r.del;
            a.answer.force_z   = r.fz;
            a.answer.throttle  = r.thr;
            pinned_answers.push_back(a);
            send_tick(t);
        end

        // Random bursts under a new setting per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            if (phase == 3)
                c = preset[2];
            else if (phase == 6)
                c = '0;
            else
            begin
                c.scaled_full_thrust = $urandom >> $urandom_range(0, 12);
                c.rise_coeff         = pick_coeff();
                c.fall_coeff         = pick_coeff();
                c.min_thrust         = ($urandom_range(0, 1) == 0) ? 32'd0 :
                                       (c.scaled_full_thrust >> $urandom_range(1, 6));
                c.dir_x              = pick_dir();
                c.dir_y              = pick_dir();
                c.dir_z              = pick_dir();
                c.flow_per_newton    = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
            end
            load_settings(c);

            sent = 0;
            while (sent < TICKS_PER_PHASE)
            begin
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst && sent < TICKS_PER_PHASE; k++)
                begin
                    pinned_answers.push_back('0);
                    send_tick(pick_tick());
                    sent++;
                end
                // Idle gap between bursts, skipped now and then
                if ($urandom_range(0, 3) != 0)
                begin
                    item_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 25)) @(posedge clk);
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- thruster_lag_model_step.f -----
rtl/tlm_pkg.sv
rtl/tlm_if.sv
rtl/tlm_cfg_regs.sv
rtl/tlm_ctrl.sv
rtl/tlm_dpath.sv
rtl/thruster_lag_model_step.sv
tb/thruster_lag_model_step_test.sv
